[design/gap_run_length_histogram_macros.svh]
// Assertion macros shared by the gap run-length histogram design.
`ifndef GAP_RUN_LENGTH_HISTOGRAM_MACROS_SVH
`define GAP_RUN_LENGTH_HISTOGRAM_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define GRLH_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define GRLH_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/grlh_pkg.sv]
// Types, constants and helper functions of the gap run-length histogram.
`default_nettype none

package grlh_pkg;

  localparam int unsigned NUM_BOUNDS  = 8;
  localparam int unsigned NUM_REGS    = 8;
  localparam int unsigned NUM_BINS    = 2 * NUM_BOUNDS + 1;
  localparam int unsigned BIN_W       = 5;
  localparam int unsigned LEN_W       = 32;
  localparam int unsigned TOTAL_W     = 48;
  localparam int unsigned CFG_IDX_W   = 4;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0]         CHAR_N_UPPER = 8'h4E;
  localparam logic [7:0]         CHAR_N_LOWER = 8'h6E;
  localparam logic [LEN_W-1:0]   LEN_MAX      = {LEN_W{1'b1}};
  localparam logic [TOTAL_W-1:0] TOTAL_MAX    = {TOTAL_W{1'b1}};

  typedef logic [NUM_REGS-1:0][LEN_W-1:0] bounds_t;

  localparam bounds_t BOUND_RESET = {
    32'd50000, 32'd10000, 32'd5000, 32'd1000, 32'd500, 32'd100, 32'd50, 32'd10
  };

  typedef enum logic [1:0] {
    MODE_BYTE  = 2'd0,
    MODE_END   = 2'd1,
    MODE_CLEAR = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    OP_REPORT = 2'd0,
    OP_RECORD = 2'd1,
    OP_CLEAR  = 2'd2
  } op_e;

  // One classified item on its way from the front to the back.
  typedef struct packed {
    op_e              op;
    logic [LEN_W-1:0] len;
    logic [BIN_W-1:0] pick;
    logic [BIN_W-1:0] bin_index;
  } work_t;

  typedef struct packed {
    logic               gap_closed;
    logic [LEN_W-1:0]   closed_length;
    logic [LEN_W-1:0]   gap_count;
    logic [TOTAL_W-1:0] total_n;
    logic [LEN_W-1:0]   min_gap;
    logic [LEN_W-1:0]   max_gap;
    logic [LEN_W-1:0]   bin_count;
  } result_t;

  function automatic logic [LEN_W-1:0] sat_inc(input logic [LEN_W-1:0] v);
    return (v == LEN_MAX) ? v : v + LEN_W'(1);
  endfunction

  // The lowest boundary that the length is below or equal to wins.
  function automatic logic [BIN_W-1:0] pick_bin(input logic [LEN_W-1:0] len,
                                                input bounds_t b);
    logic [BIN_W-1:0] pick;
    pick = BIN_W'(2 * NUM_BOUNDS);
    for (int i = NUM_BOUNDS - 1; i >= 0; i--) begin
      if (len < b[i]) begin
        pick = BIN_W'(2 * i);
      end else if (len == b[i]) begin
        pick = BIN_W'(2 * i + 1);
      end
    end
    return pick;
  endfunction

endpackage

`default_nettype wire

[design/grlh_front.sv]
// Front end: tracks the open gap, holds the boundaries and classifies each request.
`default_nettype none

module grlh_front (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [grlh_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [grlh_pkg::LEN_W-1:0]     cfg_data_i,
  input  wire logic                           in_valid_i,
  input  wire logic                           in_ready_i,
  input  wire logic [1:0]                     mode_i,
  input  wire logic [7:0]                     data_byte_i,
  input  wire logic [grlh_pkg::BIN_W-1:0]     bin_index_i,
  output grlh_pkg::work_t                     work_o
);

  logic [grlh_pkg::LEN_W-1:0] run_q, run_d;
  grlh_pkg::bounds_t          bounds_q;
  logic                       accept;
  logic                       close;

  assign accept = in_valid_i && in_ready_i;

  always_comb begin
    run_d = run_q;
    close = 1'b0;
    work_o.op = grlh_pkg::OP_REPORT;
    unique case (grlh_pkg::mode_e'(mode_i))
      grlh_pkg::MODE_BYTE: begin
        if (data_byte_i == grlh_pkg::CHAR_N_UPPER || data_byte_i == grlh_pkg::CHAR_N_LOWER) begin
          run_d = grlh_pkg::sat_inc(run_q);
        end else if (run_q != '0) begin
          close = 1'b1;
        end
      end
      grlh_pkg::MODE_END: begin
        close = (run_q != '0);
      end
      grlh_pkg::MODE_CLEAR: begin
        work_o.op = grlh_pkg::OP_CLEAR;
      end
      default: begin
      end
    endcase
    if (close) begin
      run_d     = '0;
      work_o.op = grlh_pkg::OP_RECORD;
    end
    work_o.len       = close ? run_q : '0;
    work_o.pick      = grlh_pkg::pick_bin(run_q, bounds_q);
    work_o.bin_index = bin_index_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q    <= '0;
      bounds_q <= grlh_pkg::BOUND_RESET;
    end else begin
      if (accept) begin
        run_q <= run_d;
      end
      // Writes to indexes past the last boundary are dropped.
      if (cfg_we_i && cfg_index_i < grlh_pkg::CFG_IDX_W'(grlh_pkg::NUM_REGS)) begin
        bounds_q[cfg_index_i[$clog2(grlh_pkg::NUM_REGS)-1:0]] <= cfg_data_i;
      end
    end
  end

endmodule

`default_nettype wire

[design/grlh_queue.sv]
// Short queue of classified requests between the front and the back.
`default_nettype none

module grlh_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire grlh_pkg::work_t push_data_i,
  output logic                 full_o,
  input  wire logic            pop_i,
  output logic                 valid_o,
  output grlh_pkg::work_t      pop_data_o
);

  grlh_pkg::work_t                mem_q [grlh_pkg::QUEUE_DEPTH];
  logic [grlh_pkg::PTR_W-1:0]     wr_ptr_q, rd_ptr_q;
  logic [grlh_pkg::CNT_W-1:0]     count_q;
  logic                           do_push, do_pop;

  assign full_o     = (count_q == grlh_pkg::CNT_W'(grlh_pkg::QUEUE_DEPTH));
  assign valid_o    = (count_q != '0);
  assign pop_data_o = mem_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;

  function automatic logic [grlh_pkg::PTR_W-1:0] next_ptr(
      input logic [grlh_pkg::PTR_W-1:0] p);
    return (p == grlh_pkg::PTR_W'(grlh_pkg::QUEUE_DEPTH - 1)) ? '0 :
           p + grlh_pkg::PTR_W'(1);
  endfunction

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= next_ptr(wr_ptr_q);
      end
      if (do_pop) begin
        rd_ptr_q <= next_ptr(rd_ptr_q);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + grlh_pkg::CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - grlh_pkg::CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

[design/grlh_back.sv]
// Back end: statistics, histogram counters and the output register.
`default_nettype none

module grlh_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            work_valid_i,
  input  wire grlh_pkg::work_t work_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output grlh_pkg::result_t    result_o
);

  logic [grlh_pkg::LEN_W-1:0]   gaps_q, gaps_d;
  logic [grlh_pkg::TOTAL_W-1:0] total_q, total_d;
  logic [grlh_pkg::LEN_W-1:0]   min_q, min_d;
  logic [grlh_pkg::LEN_W-1:0]   max_q, max_d;
  logic [grlh_pkg::LEN_W-1:0]   bins_q [grlh_pkg::NUM_BINS];
  logic [grlh_pkg::LEN_W-1:0]   bins_d [grlh_pkg::NUM_BINS];
  logic [grlh_pkg::TOTAL_W:0]   sum;
  logic                         out_valid_q;
  grlh_pkg::result_t            result_q, result_d;

  assign pop_o       = work_valid_i && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign result_o    = result_q;

  always_comb begin
    gaps_d  = gaps_q;
    total_d = total_q;
    min_d   = min_q;
    max_d   = max_q;
    sum     = {1'b0, total_q} + (grlh_pkg::TOTAL_W + 1)'(work_i.len);
    for (int k = 0; k < grlh_pkg::NUM_BINS; k++) begin
      bins_d[k] = bins_q[k];
    end
    unique case (work_i.op)
      grlh_pkg::OP_RECORD: begin
        gaps_d  = grlh_pkg::sat_inc(gaps_q);
        total_d = sum[grlh_pkg::TOTAL_W] ? grlh_pkg::TOTAL_MAX : sum[grlh_pkg::TOTAL_W-1:0];
        if (work_i.len < min_q) begin
          min_d = work_i.len;
        end
        if (work_i.len > max_q) begin
          max_d = work_i.len;
        end
        // Each bin has its own saturating incrementer.
        for (int k = 0; k < grlh_pkg::NUM_BINS; k++) begin
          if (work_i.pick == grlh_pkg::BIN_W'(k)) begin
            bins_d[k] = grlh_pkg::sat_inc(bins_q[k]);
          end
        end
      end
      grlh_pkg::OP_CLEAR: begin
        gaps_d  = '0;
        total_d = '0;
        min_d   = grlh_pkg::LEN_MAX;
        max_d   = '0;
        for (int k = 0; k < grlh_pkg::NUM_BINS; k++) begin
          bins_d[k] = '0;
        end
      end
      default: begin
      end
    endcase

    result_d.gap_closed    = (work_i.op == grlh_pkg::OP_RECORD);
    result_d.closed_length = work_i.len;
    result_d.gap_count     = gaps_d;
    result_d.total_n       = total_d;
    result_d.min_gap       = min_d;
    result_d.max_gap       = max_d;
    result_d.bin_count     = '0;
    for (int k = 0; k < grlh_pkg::NUM_BINS; k++) begin
      if (work_i.bin_index == grlh_pkg::BIN_W'(k)) begin
        result_d.bin_count = bins_d[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      result_q <= result_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      gaps_q      <= '0;
      total_q     <= '0;
      min_q       <= grlh_pkg::LEN_MAX;
      max_q       <= '0;
      for (int k = 0; k < grlh_pkg::NUM_BINS; k++) begin
        bins_q[k] <= '0;
      end
    end else begin
      if (pop_o) begin
        out_valid_q <= 1'b1;
        gaps_q      <= gaps_d;
        total_q     <= total_d;
        min_q       <= min_d;
        max_q       <= max_d;
        for (int k = 0; k < grlh_pkg::NUM_BINS; k++) begin
          bins_q[k] <= bins_d[k];
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

[design/gap_run_length_histogram.sv]
// Top level of the gap run-length histogram: front, queue, back and port packing.
//
//   Channel   Direction  Handshake                Contents
//   s_*       in         s_tvalid_i / s_tready_o  sequence byte, end, clear request
//   m_*       out        m_tvalid_o / m_tready_i  statistics and one bin count
//   cfg_*     in         cfg_we_i                 histogram boundaries, index 0..7
//
// One request per cycle sustained while the output is not stalled; a taken request is
// first written into the two-entry queue, then the back loads the output register
// from it, after which the result can be accepted.
// Reset restores the default boundaries and clears all counters at once; all 17
// bins live in flip-flops, so there is no clearing pass.
// A stalled output fills the queue and then drops s_tready_o.
`default_nettype none
`include "gap_run_length_histogram_macros.svh"

module gap_run_length_histogram (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           s_tvalid_i,
  output logic                                s_tready_o,
  input  wire logic [15:0]                    s_tdata_i,  // data_byte, bin_index
  input  wire logic [1:0]                     s_tuser_i,  // mode
  output logic                                m_tvalid_o,
  input  wire logic                           m_tready_i,
  // closed_length, gap_count, total_n, min_gap, max_gap, bin_count
  output logic [207:0]                        m_tdata_o,
  output logic [0:0]                          m_tuser_o,  // gap_closed
  input  wire logic                           cfg_we_i,
  input  wire logic [grlh_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [grlh_pkg::LEN_W-1:0]     cfg_data_i
);

  grlh_pkg::work_t   front_work;
  grlh_pkg::work_t   q_work;
  grlh_pkg::result_t result;
  logic              q_full;
  logic              q_valid;
  logic              q_pop;

  assign s_tready_o = !q_full;

  grlh_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (s_tvalid_i),
    .in_ready_i  (s_tready_o),
    .mode_i      (s_tuser_i),
    .data_byte_i (s_tdata_i[7:0]),
    .bin_index_i (s_tdata_i[12:8]),
    .work_o      (front_work)
  );

  grlh_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (s_tvalid_i),
    .push_data_i (front_work),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_data_o  (q_work)
  );

  grlh_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .work_valid_i (q_valid),
    .work_i       (q_work),
    .pop_o        (q_pop),
    .out_valid_o  (m_tvalid_o),
    .out_ready_i  (m_tready_i),
    .result_o     (result)
  );

  assign m_tuser_o = result.gap_closed;
  assign m_tdata_o = {result.bin_count, result.max_gap, result.min_gap,
                      result.total_n, result.gap_count, result.closed_length};

  `GRLH_ASSERT_IMPL(a_closed_len, m_tvalid_o,
                    result.gap_closed == (result.closed_length != '0),
                    "closed flag and length disagree")
  `GRLH_ASSERT_IMPL(a_min_le_max, m_tvalid_o && result.gap_count != '0,
                    result.min_gap <= result.max_gap,
                    "shortest gap exceeds longest gap")
  `GRLH_ASSERT_IMPL(a_empty_stats, m_tvalid_o && result.gap_count == '0,
                    result.total_n == '0 && result.min_gap == grlh_pkg::LEN_MAX &&
                    result.max_gap == '0,
                    "statistics not empty with no gaps")
  `GRLH_ASSERT_NEXT(a_clear_result, q_pop && q_work.op == grlh_pkg::OP_CLEAR,
                    m_tvalid_o && result.gap_count == '0 && result.bin_count == '0 &&
                    !result.gap_closed,
                    "clear request left counts behind")

endmodule

`default_nettype wire
